// ===== src/shelf_row_part_placer_core_assert.svh =====
// Assertion macros for the shelf row part placer checks
`ifndef SHELF_ROW_PART_PLACER_CORE_ASSERT_SVH
`define SHELF_ROW_PART_PLACER_CORE_ASSERT_SVH

// same-cycle implication
`define SRPP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shelf placer check failed");

// next-cycle implication
`define SRPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shelf placer check failed");

`endif

// ===== src/srpp_pkg.sv =====
// Types, codes and saturation helpers shared by the shelf row part placer
`timescale 1ns / 1ps

package srpp_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 30;

   localparam logic [CSR_INDEX_W-1:0] CSR_PLATE_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLATE_WIDTH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EDGE_MARGIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PART_GAP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_AXIS     = 3'd4;

   typedef enum logic [1:0] {
      ST_SAME_ROW = 2'd0,
      ST_NEW_ROW  = 2'd1,
      ST_NO_FIT   = 2'd2,
      ST_SKIPPED  = 2'd3
   } place_status_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] plate_length;
      logic [CSR_DATA_W-1:0] plate_width;
      logic [CSR_DATA_W-1:0] edge_margin;
      logic [CSR_DATA_W-1:0] part_gap;
      logic                  row_axis;
   } srpp_cfg_type;

   typedef struct packed {
      logic               first_part;
      logic               box_valid;
      logic signed [30:0] min_x;
      logic signed [30:0] min_y;
      logic signed [30:0] min_z;
      logic signed [31:0] len_x;
      logic signed [31:0] len_y;
   } srpp_item_type;

   typedef struct packed {
      logic signed [33:0] cursor_x;
      logic signed [33:0] cursor_y;
      logic signed [33:0] row_extent;
      logic               job_failed;
   } srpp_state_type;

   typedef struct packed {
      logic signed [31:0] move_x;
      logic signed [31:0] move_y;
      logic signed [31:0] move_z;
      place_status_type   place_status;
   } srpp_result_type;

   function automatic logic signed [33:0] sat34(input logic signed [35:0] v);
      if (v[35:33] == 3'b000 || v[35:33] == 3'b111) begin
         return signed'(v[33:0]);
      end else if (v[35]) begin
         return signed'({1'b1, {33{1'b0}}});
      end else begin
         return signed'({1'b0, {33{1'b1}}});
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
         return signed'(v[31:0]);
      end else if (v[35]) begin
         return signed'({1'b1, {31{1'b0}}});
      end else begin
         return signed'({1'b0, {31{1'b1}}});
      end
   endfunction

endpackage

// ===== src/srpp_ifs.sv =====
// Request and response channel interfaces of the shelf row part placer
`timescale 1ns / 1ps

interface srpp_req_if import srpp_pkg::*;;
   logic               valid;
   logic               ready;
   logic               first_part;
   logic               box_valid;
   logic signed [30:0] min_x;
   logic signed [30:0] min_y;
   logic signed [30:0] min_z;
   logic signed [30:0] max_x;
   logic signed [30:0] max_y;

   modport source (output valid, first_part, box_valid, min_x, min_y, min_z, max_x, max_y,
                   input ready);
   modport sink (input valid, first_part, box_valid, min_x, min_y, min_z, max_x, max_y,
                 output ready);
endinterface

interface srpp_rsp_if import srpp_pkg::*;;
   logic               valid;
   logic               ready;
   logic signed [31:0] move_x;
   logic signed [31:0] move_y;
   logic signed [31:0] move_z;
   place_status_type   place_status;

   modport source (output valid, move_x, move_y, move_z, place_status, input ready);
   modport sink (input valid, move_x, move_y, move_z, place_status, output ready);
endinterface

// ===== src/srpp_place.sv =====
// Placement datapath: fit tests, row opening, moves and next cursor state
`timescale 1ns / 1ps

module srpp_place import srpp_pkg::*; (
   input  srpp_cfg_type    cfg,
   input  srpp_state_type  state_cur,
   input  srpp_item_type   item,
   output srpp_state_type  state_nxt,
   output srpp_result_type result
);

   logic signed [35:0] marg_s;
   logic signed [35:0] gap_s;
   logic signed [35:0] lim_x;
   logic signed [35:0] lim_y;
   logic signed [33:0] marg_34;
   srpp_state_type     eff;
   logic signed [33:0] open_x;
   logic signed [33:0] open_y;
   logic signed [33:0] plc_x;
   logic signed [33:0] plc_y;
   logic signed [33:0] plc_re;
   logic               fit_cur;
   logic               fit_open;

   assign marg_s  = signed'(36'(cfg.edge_margin));
   assign gap_s   = signed'(36'(cfg.part_gap));
   assign marg_34 = signed'(34'(cfg.edge_margin));
   assign lim_x   = signed'(36'(cfg.plate_length)) - marg_s;
   assign lim_y   = signed'(36'(cfg.plate_width)) - marg_s;

   // new job resets the placement state before this part is handled
   always_comb begin
      eff = state_cur;
      if (item.first_part) begin
         eff.cursor_x   = marg_34;
         eff.cursor_y   = marg_34;
         eff.row_extent = '0;
         eff.job_failed = 1'b0;
      end
   end

   always_comb begin
      if (cfg.row_axis) begin
         open_x = sat34(36'(eff.cursor_x) + 36'(eff.row_extent) + gap_s);
         open_y = marg_34;
      end else begin
         open_x = marg_34;
         open_y = sat34(36'(eff.cursor_y) + 36'(eff.row_extent) + gap_s);
      end
   end

   assign fit_cur  = (36'(eff.cursor_x) + 36'(item.len_x) <= lim_x) &&
                     (36'(eff.cursor_y) + 36'(item.len_y) <= lim_y);
   assign fit_open = (36'(open_x) + 36'(item.len_x) <= lim_x) &&
                     (36'(open_y) + 36'(item.len_y) <= lim_y);

   assign plc_x  = fit_cur ? eff.cursor_x : open_x;
   assign plc_y  = fit_cur ? eff.cursor_y : open_y;
   assign plc_re = fit_cur ? eff.row_extent : '0;

   always_comb begin
      state_nxt           = eff;
      result              = '0;
      result.place_status = ST_SKIPPED;
      if (eff.job_failed) begin
         result.place_status = ST_SKIPPED;
      end else if (!item.box_valid) begin
         state_nxt.job_failed = 1'b1;
         result.place_status  = ST_SKIPPED;
      end else if (!fit_cur && !fit_open) begin
         state_nxt.job_failed = 1'b1;
         result.place_status  = ST_NO_FIT;
      end else begin
         result.place_status = fit_cur ? ST_SAME_ROW : ST_NEW_ROW;
         result.move_x       = sat32(36'(plc_x) - 36'(item.min_x));
         result.move_y       = sat32(36'(plc_y) - 36'(item.min_y));
         result.move_z       = -(32'(item.min_z));
         if (cfg.row_axis) begin
            state_nxt.cursor_x   = plc_x;
            state_nxt.cursor_y   = sat34(36'(plc_y) + 36'(item.len_y) + gap_s);
            state_nxt.row_extent = (item.len_x > plc_re) ? 34'(item.len_x) : plc_re;
         end else begin
            state_nxt.cursor_x   = sat34(36'(plc_x) + 36'(item.len_x) + gap_s);
            state_nxt.cursor_y   = plc_y;
            state_nxt.row_extent = (item.len_y > plc_re) ? 34'(item.len_y) : plc_re;
         end
      end
   end

endmodule

// ===== src/shelf_row_part_placer_core.sv =====
// Shelf row part placer top level: request register, placement, response register
//
// Usage: each request on req_bus carries one part's bounding box (Q15.16) plus
// first_part and box_valid; each request yields exactly one response on
// rsp_bus with the move and a placement status, in request order.
// The user writes plate size, margin, gap and row direction through csr_we / csr_index /
// csr_wdata only while no request is in flight; the block itself does not enforce it.
// Path: a request accepted into the request register is placed combinationally and its
// result is captured in the response register, where it is valid on rsp_bus. Throughput:
// one request per cycle, sustained while the receiver does not stall rsp_bus.
// That rate is bounded by the cursor/row-extent update loop: the next
// part's fit test reads the state the current part writes.
// Reset clears the configuration, the cursors, row extent, the failure flag
// and both stage valids.
// When the receiver stalls, the response register holds; the request register takes one
// more request only if it is empty, then req_bus.ready stays low until rsp_bus.ready.
`timescale 1ns / 1ps

module shelf_row_part_placer_core import srpp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   srpp_req_if.sink               req_bus,
   srpp_rsp_if.source             rsp_bus
);

   srpp_cfg_type    cfg_ff;
   srpp_state_type  state_ff;
   srpp_state_type  state_in;
   srpp_item_type   item_ff;
   srpp_item_type   item_in;
   srpp_result_type result_ff;
   srpp_result_type result_in;
   logic            s1_valid_ff;
   logic            rsp_valid_ff;
   logic            s1_adv;
   logic            s1_fire;
   logic            req_ready;
   logic            req_fire;

   assign s1_adv    = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire   = s1_valid_ff && s1_adv;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_bus.valid && req_ready;

   assign req_bus.ready = req_ready;

   always_comb begin
      item_in.first_part = req_bus.first_part;
      item_in.box_valid  = req_bus.box_valid;
      item_in.min_x      = req_bus.min_x;
      item_in.min_y      = req_bus.min_y;
      item_in.min_z      = req_bus.min_z;
      item_in.len_x      = 32'(req_bus.max_x) - 32'(req_bus.min_x);
      item_in.len_y      = 32'(req_bus.max_y) - 32'(req_bus.min_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PLATE_LENGTH: cfg_ff.plate_length <= csr_wdata;
            CSR_PLATE_WIDTH:  cfg_ff.plate_width  <= csr_wdata;
            CSR_EDGE_MARGIN:  cfg_ff.edge_margin  <= csr_wdata;
            CSR_PART_GAP:     cfg_ff.part_gap     <= csr_wdata;
            CSR_ROW_AXIS:     cfg_ff.row_axis     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   srpp_place u_place (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (s1_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.move_x       = result_ff.move_x;
   assign rsp_bus.move_y       = result_ff.move_y;
   assign rsp_bus.move_z       = result_ff.move_z;
   assign rsp_bus.place_status = result_ff.place_status;

endmodule

// ===== src/srpp_checker.sv =====
// Port-level checks for the shelf row part placer, bound to the top level
`timescale 1ns / 1ps

`include "shelf_row_part_placer_core_assert.svh"

module srpp_checker import srpp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] move_x,
   input logic signed [31:0] move_y,
   input logic signed [31:0] move_z,
   input place_status_type   place_status
);

   `SRPP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SRPP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(move_x) && $stable(move_y) && $stable(move_z) && $stable(place_status))
   `SRPP_ASSERT_IMPLY(a_no_move_unplaced, clock, reset, rsp_valid && (place_status == ST_NO_FIT || place_status == ST_SKIPPED), move_x == 32'sd0 && move_y == 32'sd0 && move_z == 32'sd0)
   `SRPP_ASSERT_IMPLY(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind shelf_row_part_placer_core srpp_checker u_srpp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .move_x       (rsp_bus.move_x),
   .move_y       (rsp_bus.move_y),
   .move_z       (rsp_bus.move_z),
   .place_status (rsp_bus.place_status)
);
